### rtl/gsec_pkg.sv
`default_nettype none

package gsec_pkg;

    localparam int CHAR_W = 8;
    localparam int CNT_W  = 7;
    localparam logic [CNT_W-1:0] ERR_MAX = 7'd127;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef struct packed {
        logic start;
    } scan_req_t;

    typedef struct packed {
        logic   done;
        count_t error_count;
    } scan_rsp_t;

endpackage

`default_nettype wire

### rtl/greedy_string_error_count_unit.sv
`default_nettype none

// Greedy edit error count between two byte strings. Each input transaction
// carries one position of both strings (a zero byte ends a string, later
// bytes of that string are ignored); bytes are loaded at one pair per cycle
// while s_tready is high. The transaction with s_tlast set closes the pair
// and starts the scan, which gives one result transaction: m_tdata holds the
// error count, saturated at 127, and m_tuser flags a string longer than
// MAX_LEN (count then 0, and no scan runs). The scan reads the two string
// memories, one read port each. A matching position of the shorter string
// advances by one position; at a mismatch, a swap or a substitution followed
// by a match covers two positions, and at most two deletion tests compare
// the remaining suffixes.
// Input is held off from the last transaction until the result is in the
// output register; the next pair may load while that result waits.
module greedy_string_error_count_unit #(
    parameter int MAX_LEN = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // a_char, b_char
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // error_count, zero pad
    output logic             m_tuser    // overflow
);
    import gsec_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_OUT
    } top_state_t;

    top_state_t    state_reg, state_next;
    logic [LW-1:0] len_a_reg, len_a_next;
    logic [LW-1:0] len_b_reg, len_b_next;
    logic          end_a_reg, end_a_next;
    logic          end_b_reg, end_b_next;
    logic          too_long_reg, too_long_next;
    logic          start_reg, start_next;
    count_t        res_count_reg, res_count_next;
    logic          res_ovf_reg, res_ovf_next;
    logic          m_valid_reg, m_valid_next;
    count_t        m_count_reg, m_count_next;
    logic          m_ovf_reg, m_ovf_next;

    char_t         a_char, b_char;
    logic          s_accept;
    logic          a_we, b_we;
    char_t         a_rdata, b_rdata;
    logic [AW-1:0] a_raddr, b_raddr;
    scan_req_t     scan_req;
    scan_rsp_t     scan_rsp;

    assign a_char   = s_tdata[7:0];
    assign b_char   = s_tdata[15:8];
    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;

    assign a_we = s_accept && !end_a_reg && a_char != 8'd0 && len_a_reg < LW'(MAX_LEN);
    assign b_we = s_accept && !end_b_reg && b_char != 8'd0 && len_b_reg < LW'(MAX_LEN);

    assign scan_req.start = start_reg;

    gsec_store #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_store (
        .aclk    (aclk),
        .a_we    (a_we),
        .a_waddr (len_a_reg[AW-1:0]),
        .a_wdata (a_char),
        .b_we    (b_we),
        .b_waddr (len_b_reg[AW-1:0]),
        .b_wdata (b_char),
        .a_raddr (a_raddr),
        .b_raddr (b_raddr),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata)
    );

    gsec_scan #(
        .AW (AW),
        .LW (LW)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scan_req),
        .len_a   (len_a_reg),
        .len_b   (len_b_reg),
        .a_raddr (a_raddr),
        .b_raddr (b_raddr),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata),
        .rsp     (scan_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        len_a_next     = len_a_reg;
        len_b_next     = len_b_reg;
        end_a_next     = end_a_reg;
        end_b_next     = end_b_reg;
        too_long_next  = too_long_reg;
        start_next     = 1'b0;
        res_count_next = res_count_reg;
        res_ovf_next   = res_ovf_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_count_next   = m_count_reg;
        m_ovf_next     = m_ovf_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (!end_a_reg) begin
                        if (a_char == 8'd0) begin
                            end_a_next = 1'b1;
                        end else if (a_we) begin
                            len_a_next = len_a_reg + 1'b1;
                        end else begin
                            too_long_next = 1'b1;
                        end
                    end
                    if (!end_b_reg) begin
                        if (b_char == 8'd0) begin
                            end_b_next = 1'b1;
                        end else if (b_we) begin
                            len_b_next = len_b_reg + 1'b1;
                        end else begin
                            too_long_next = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        if (too_long_next) begin
                            res_count_next = '0;
                            res_ovf_next   = 1'b1;
                            state_next     = ST_OUT;
                        end else begin
                            start_next = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (scan_rsp.done) begin
                    res_count_next = scan_rsp.error_count;
                    res_ovf_next   = 1'b0;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_count_next  = res_count_reg;
                    m_ovf_next    = res_ovf_reg;
                    len_a_next    = '0;
                    len_b_next    = '0;
                    end_a_next    = 1'b0;
                    end_b_next    = 1'b0;
                    too_long_next = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            len_a_reg    <= '0;
            len_b_reg    <= '0;
            end_a_reg    <= 1'b0;
            end_b_reg    <= 1'b0;
            too_long_reg <= 1'b0;
            start_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_a_reg    <= len_a_next;
            len_b_reg    <= len_b_next;
            end_a_reg    <= end_a_next;
            end_b_reg    <= end_b_next;
            too_long_reg <= too_long_next;
            start_reg    <= start_next;
            m_valid_reg  <= m_valid_next;
        end
        res_count_reg <= res_count_next;
        res_ovf_reg   <= res_ovf_next;
        m_count_reg   <= m_count_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg};
    assign m_tuser  = m_ovf_reg;

endmodule

`default_nettype wire

### rtl/gsec_store.sv
`default_nettype none

module gsec_store #(
    parameter int MAX_LEN = 64,
    parameter int AW      = 6
) (
    input  wire logic           aclk,
    input  wire logic           a_we,
    input  wire logic [AW-1:0]  a_waddr,
    input  wire gsec_pkg::char_t a_wdata,
    input  wire logic           b_we,
    input  wire logic [AW-1:0]  b_waddr,
    input  wire gsec_pkg::char_t b_wdata,
    input  wire logic [AW-1:0]  a_raddr,
    input  wire logic [AW-1:0]  b_raddr,
    output gsec_pkg::char_t     a_rdata,
    output gsec_pkg::char_t     b_rdata
);
    import gsec_pkg::*;

    char_t a_mem [MAX_LEN];
    char_t b_mem [MAX_LEN];
    char_t a_rdata_reg;
    char_t b_rdata_reg;

    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= a_wdata;
        end
        a_rdata_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_waddr] <= b_wdata;
        end
        b_rdata_reg <= b_mem[b_raddr];
    end

    assign a_rdata = a_rdata_reg;
    assign b_rdata = b_rdata_reg;

endmodule

`default_nettype wire

### rtl/gsec_scan.sv
`default_nettype none

module gsec_scan #(
    parameter int AW = 6,
    parameter int LW = 7
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire gsec_pkg::scan_req_t req,
    input  wire logic [LW-1:0]       len_a,
    input  wire logic [LW-1:0]       len_b,
    output logic [AW-1:0]            a_raddr,
    output logic [AW-1:0]            b_raddr,
    input  wire gsec_pkg::char_t     a_rdata,
    input  wire gsec_pkg::char_t     b_rdata,
    output gsec_pkg::scan_rsp_t      rsp
);
    import gsec_pkg::*;

    localparam int DW = (LW > CNT_W) ? LW : CNT_W;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_CHK,
        SC_RC,
        SC_RN,
        SC_SUF,
        SC_DONE
    } sc_state_t;

    sc_state_t      state_reg, state_next;
    logic [LW-1:0]  i_reg, i_next;
    logic [LW-1:0]  min_reg, min_next;
    logic           a_longer_reg, a_longer_next;
    count_t         err_reg, err_next;
    logic [1:0]     chances_reg, chances_next;
    char_t          c1_reg, c1_next;
    char_t          c2_reg, c2_next;
    logic [LW-1:0]  sa_reg, sa_next;
    logic [LW-1:0]  sb_reg, sb_next;
    logic [LW-1:0]  rem_reg, rem_next;
    logic           pend_reg, pend_next;

    logic [LW-1:0]  i_inc1;
    logic [LW-1:0]  i_inc2;
    logic [LW-1:0]  diff;
    logic [DW-1:0]  diff_ext;
    char_t          fc1, fc2, fa, fb;

    function automatic char_t fold_upper(char_t c);
        if (c >= 8'h61 && c <= 8'h7a) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic count_t sat_inc(count_t v);
        if (v == ERR_MAX) begin
            return v;
        end
        return v + 1'b1;
    endfunction

    assign i_inc1   = i_reg + 1'b1;
    assign i_inc2   = i_reg + 2'd2;
    assign diff     = (len_a > len_b) ? len_a - len_b : len_b - len_a;
    assign diff_ext = DW'(diff);
    assign fc1      = fold_upper(c1_reg);
    assign fc2      = fold_upper(c2_reg);
    assign fa       = fold_upper(a_rdata);
    assign fb       = fold_upper(b_rdata);

    always_comb begin
        a_raddr = i_reg[AW-1:0];
        b_raddr = i_reg[AW-1:0];
        case (state_reg)
            SC_RC: begin
                a_raddr = i_inc1[AW-1:0];
                b_raddr = i_inc1[AW-1:0];
            end
            SC_SUF: begin
                a_raddr = sa_reg[AW-1:0];
                b_raddr = sb_reg[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        min_next      = min_reg;
        a_longer_next = a_longer_reg;
        err_next      = err_reg;
        chances_next  = chances_reg;
        c1_next       = c1_reg;
        c2_next       = c2_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        rem_next      = rem_reg;
        pend_next     = pend_reg;
        case (state_reg)
            SC_IDLE: begin
                if (req.start) begin
                    min_next      = (len_a < len_b) ? len_a : len_b;
                    a_longer_next = len_a > len_b;
                    err_next      = (diff_ext > DW'(ERR_MAX)) ? ERR_MAX : diff_ext[CNT_W-1:0];
                    chances_next  = (diff == LW'(1)) ? 2'd2 : 2'd0;
                    i_next        = '0;
                    state_next    = SC_CHK;
                end
            end
            SC_CHK: begin
                state_next = (i_reg < min_reg) ? SC_RC : SC_DONE;
            end
            SC_RC: begin
                if (i_inc1 == min_reg) begin
                    if (a_rdata != b_rdata) begin
                        err_next = sat_inc(err_reg);
                    end
                    state_next = SC_DONE;
                end else if (fa == fb) begin
                    i_next     = i_inc1;
                    state_next = SC_CHK;
                end else begin
                    c1_next    = a_rdata;
                    c2_next    = b_rdata;
                    state_next = SC_RN;
                end
            end
            SC_RN: begin
                if ((fa == fc2 && fc1 == fb) || fa == fb) begin
                    err_next   = sat_inc(err_reg);
                    i_next     = i_inc2;
                    state_next = SC_CHK;
                end else if (chances_reg != 2'd0) begin
                    sa_next    = a_longer_reg ? i_inc1 : i_reg;
                    sb_next    = a_longer_reg ? i_reg : i_inc1;
                    rem_next   = min_reg - i_reg;
                    pend_next  = 1'b0;
                    state_next = SC_SUF;
                end else begin
                    err_next   = sat_inc(err_reg);
                    i_next     = i_inc1;
                    state_next = SC_CHK;
                end
            end
            SC_SUF: begin
                if (pend_reg && fa != fb) begin
                    chances_next = chances_reg - 1'b1;
                    err_next     = sat_inc(err_reg);
                    i_next       = i_inc1;
                    state_next   = SC_CHK;
                end else if (rem_reg == '0) begin
                    state_next = SC_DONE;
                end else begin
                    sa_next   = sa_reg + 1'b1;
                    sb_next   = sb_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    pend_next = 1'b1;
                end
            end
            SC_DONE: begin
                state_next = SC_IDLE;
            end
            default: begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        i_reg        <= i_next;
        min_reg      <= min_next;
        a_longer_reg <= a_longer_next;
        err_reg      <= err_next;
        chances_reg  <= chances_next;
        c1_reg       <= c1_next;
        c2_reg       <= c2_next;
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        rem_reg      <= rem_next;
    end

    assign rsp.done        = (state_reg == SC_DONE);
    assign rsp.error_count = err_reg;

endmodule

`default_nettype wire
